// File: hdl/page_bitmap_allocator_macros.svh
// Assertion macros shared by the page bitmap allocator RTL.
`ifndef PAGE_BITMAP_ALLOCATOR_MACROS_SVH
`define PAGE_BITMAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked on the rising edge outside reset.
`define PBA_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("page_bitmap_allocator: assertion failed");

// Next-cycle implication, checked on the rising edge outside reset.
`define PBA_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("page_bitmap_allocator: assertion failed");

`endif

// File: hdl/pba_pkg.sv
// Shared types, constants and helpers of the page bitmap allocator.
package pba_pkg;

	localparam int PAGE_COUNT = 131072;
	localparam int PAGE_SHIFT = 13;
	localparam int WORDS      = PAGE_COUNT / 32;
	localparam int WORD_AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int PAGE_IW    = WORD_AW + 5;

	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	localparam logic [31:0] MEMORY_BASE_RESET = 32'h4000_0000;

	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_MARK  = 2'd1;
	localparam logic [1:0] KIND_FREE  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOMEM = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef enum logic [2:0] {
		OP_ALLOC,
		OP_MARK,
		OP_FREE,
		OP_RANGE,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [WORD_AW-1:0] word;
		logic [4:0]         bit_idx;
	} cmd_t;

	typedef struct packed {
		logic clearing;
		logic idle;
	} back_stat_t;

	// Next word index with wrap at the last word.
	function automatic logic [WORD_AW-1:0] next_word(input logic [WORD_AW-1:0] w);
		return (w == WORD_AW'(WORDS - 1)) ? '0 : WORD_AW'(w + 1'b1);
	endfunction

	// Position of the lowest clear bit (isolate it, then encode the one-hot).
	function automatic logic [4:0] lowest_zero(input logic [31:0] w);
		logic [31:0] inv;
		logic [31:0] oh;
		logic [4:0]  idx;
		inv = ~w;
		oh  = inv & (~inv + 32'd1);
		idx = '0;
		for (int i = 0; i < 32; i++) begin
			if (oh[i]) begin
				idx = idx | 5'(i);
			end
		end
		return idx;
	endfunction

endpackage

// File: hdl/pba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pba_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/pba_front.sv
// Front end: accepts requests, works out the page index and classifies them.
module pba_front import pba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  kind,
	input  logic [31:0] page_address,
	input  logic [31:0] memory_base,
	input  logic        clearing,
	input  logic        q_full,
	output logic        busy,
	output logic        q_push,
	output cmd_t        q_data
);

	logic        vld_s1;
	cmd_t        cmd_s1;
	logic        accept;
	logic [31:0] offset;
	logic [31:0] page_full;
	logic        in_range;
	cmd_t        cmd_d;

	assign busy   = clearing || (vld_s1 && q_full);
	assign accept = start && !busy;
	assign q_push = vld_s1 && !q_full;
	assign q_data = cmd_s1;

	// offset wraps modulo 2^32
	assign offset    = page_address - memory_base;
	assign page_full = offset >> PAGE_SHIFT;
	assign in_range  = page_full < 32'(PAGE_COUNT);

	always_comb begin
		cmd_d.word    = page_full[PAGE_IW-1:5];
		cmd_d.bit_idx = page_full[4:0];
		unique case (kind)
			KIND_ALLOC: cmd_d.op = OP_ALLOC;
			KIND_MARK:  cmd_d.op = in_range ? OP_MARK : OP_RANGE;
			KIND_FREE:  cmd_d.op = in_range ? OP_FREE : OP_RANGE;
			default:    cmd_d.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (q_push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

// File: hdl/pba_queue.sv
// Short command queue between front end and back end.
module pba_queue import pba_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cmd_t            push_data,
	input  logic            pop,
	output cmd_t            pop_data,
	output logic            full,
	output logic            empty,
	output logic [Q_CW-1:0] count
);

	cmd_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full     = count_q == Q_CW'(Q_DEPTH);
	assign empty    = count_q == '0;
	assign count    = count_q;
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;

	function automatic logic [Q_AW-1:0] q_next(input logic [Q_AW-1:0] p);
		return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : Q_AW'(p + 1'b1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= q_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= q_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= Q_CW'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= Q_CW'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: hdl/pba_back.sv
// Back end: clears the bitmap, runs next-fit scans and mark/free updates.
module pba_back import pba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] memory_base,
	input  cmd_t        q_data,
	input  logic        q_empty,
	output logic        q_pop,
	output back_stat_t  stat,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] result_address
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_RMW
	} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	logic [WORD_AW-1:0] start_word_q;
	logic [WORD_AW-1:0] issue_ptr_q;
	logic [WORD_AW-1:0] chk_ptr_q;
	logic [WORD_AW-1:0] chk_cnt_q;
	logic [WORD_AW-1:0] clr_ptr_q;
	logic               done_q;
	logic [1:0]         status_q;
	logic [31:0]        addr_q;

	logic               ram_we;
	logic [WORD_AW-1:0] ram_waddr;
	logic [31:0]        ram_wdata;
	logic [WORD_AW-1:0] ram_raddr;
	logic [31:0]        ram_rdata;
	logic [4:0]         free_bit;
	logic               word_full;
	logic [31:0]        cmd_mask;
	logic [PAGE_IW-1:0] found_page;

	pba_ram #(
		.WIDTH (32),
		.DEPTH (WORDS),
		.ADDR_W(WORD_AW)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign free_bit   = lowest_zero(ram_rdata);
	assign word_full  = ram_rdata == '1;
	assign cmd_mask   = 32'd1 << cmd_q.bit_idx;
	assign found_page = {chk_ptr_q, free_bit};

	assign q_pop         = (state_q == S_IDLE) && !q_empty;
	assign stat.clearing = state_q == S_CLEAR;
	assign stat.idle     = state_q == S_IDLE;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = chk_ptr_q;
		ram_wdata = ram_rdata | (32'd1 << free_bit);
		ram_raddr = issue_ptr_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_ptr_q;
				ram_wdata = '0;
			end
			S_IDLE: begin
				ram_raddr = (q_data.op == OP_ALLOC) ? start_word_q : q_data.word;
			end
			S_SCAN: begin
				ram_we = !word_full;
			end
			S_RMW: begin
				ram_we    = 1'b1;
				ram_waddr = cmd_q.word;
				ram_wdata = (cmd_q.op == OP_MARK) ? (ram_rdata | cmd_mask)
				                                  : (ram_rdata & ~cmd_mask);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			cmd_q        <= '{op: OP_NOP, word: '0, bit_idx: '0};
			start_word_q <= '0;
			issue_ptr_q  <= '0;
			chk_ptr_q    <= '0;
			chk_cnt_q    <= '0;
			clr_ptr_q    <= '0;
			done_q       <= 1'b0;
			status_q     <= ST_OK;
			addr_q       <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_ptr_q <= next_word(clr_ptr_q);
					if (clr_ptr_q == WORD_AW'(WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (!q_empty) begin
						cmd_q <= q_data;
						case (q_data.op) inside
							OP_ALLOC: begin
								chk_ptr_q   <= start_word_q;
								issue_ptr_q <= next_word(start_word_q);
								chk_cnt_q   <= '0;
								state_q     <= S_SCAN;
							end
							OP_MARK, OP_FREE: begin
								state_q <= S_RMW;
							end
							OP_RANGE: begin
								done_q   <= 1'b1;
								status_q <= ST_RANGE;
								addr_q   <= '0;
							end
							default: begin
								done_q   <= 1'b1;
								status_q <= ST_OK;
								addr_q   <= '0;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (!word_full) begin
						done_q       <= 1'b1;
						status_q     <= ST_OK;
						addr_q       <= memory_base + (32'(found_page) << PAGE_SHIFT);
						start_word_q <= chk_ptr_q;
						state_q      <= S_IDLE;
					end else if (chk_cnt_q == WORD_AW'(WORDS - 1)) begin
						done_q   <= 1'b1;
						status_q <= ST_NOMEM;
						addr_q   <= '0;
						state_q  <= S_IDLE;
					end else begin
						chk_ptr_q   <= next_word(chk_ptr_q);
						issue_ptr_q <= next_word(issue_ptr_q);
						chk_cnt_q   <= WORD_AW'(chk_cnt_q + 1'b1);
					end
				end
				S_RMW: begin
					done_q   <= 1'b1;
					status_q <= ST_OK;
					addr_q   <= '0;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign result_address = addr_q;

endmodule

// File: hdl/page_bitmap_allocator.sv
// Top level of the next-fit page bitmap allocator.
//
// One bit per physical page, 32 pages to a bitmap word, held in a RAM of
// WORDS words (4096 at the default size). After reset the block runs a
// clearing pass that writes one word a cycle and holds busy high
// throughout. A transaction is taken on a rising edge with start high and
// busy low; each one yields exactly one result, shown for a single cycle
// with done high, which the receiver must take as it comes. Results leave
// in request order. An allocate examines from 1 up to WORDS bitmap words,
// as the scan reads one word per cycle through the RAM read port. The
// front stage and a two-entry queue let up to three further requests be
// taken while the back end scans.
// memory_base may be written only while no transaction is outstanding.
module page_bitmap_allocator import pba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [31:0] page_address,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] result_address
);

`include "page_bitmap_allocator_macros.svh"

	logic [31:0]     memory_base_q;
	back_stat_t      back_stat;
	logic            q_push;
	cmd_t            q_push_data;
	logic            q_pop;
	cmd_t            q_pop_data;
	logic            q_full;
	logic            q_empty;
	logic [Q_CW-1:0] q_count;

	// single configuration register, one base for the whole store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			memory_base_q <= MEMORY_BASE_RESET;
		end else if (cfg_we) begin
			memory_base_q <= cfg_data;
		end
	end

	// front: takes the transaction, computes page index and range check
	pba_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.kind        (kind),
		.page_address(page_address),
		.memory_base (memory_base_q),
		.clearing    (back_stat.clearing),
		.q_full      (q_full),
		.busy        (busy),
		.q_push      (q_push),
		.q_data      (q_push_data)
	);

	// decouples classification from the bitmap work
	pba_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_push_data),
		.pop      (q_pop),
		.pop_data (q_pop_data),
		.full     (q_full),
		.empty    (q_empty),
		.count    (q_count)
	);

	// back: owns the bitmap RAM and the next-fit start word
	pba_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.memory_base   (memory_base_q),
		.q_data        (q_pop_data),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.stat          (back_stat),
		.done          (done),
		.status        (status),
		.result_address(result_address)
	);

	// failed or non-allocating results carry a zero address
	`PBA_ASSERT_IMPLIES(a_err_addr_zero, clk, arst_n, done && status != ST_OK, result_address == '0)
	// no result can appear while the bitmap is still being cleared
	`PBA_ASSERT_IMPLIES(a_no_done_clearing, clk, arst_n, back_stat.clearing, !done && busy)
	// queue occupancy never exceeds its depth
	`PBA_ASSERT_IMPLIES(a_queue_bound, clk, arst_n, 1'b1, q_count <= Q_CW'(Q_DEPTH))
	// a popped entry means the back end leaves idle or reports next cycle
	`PBA_ASSERT_NEXT(a_pop_progress, clk, arst_n, q_pop, done || !back_stat.idle)

endmodule

// File: tb/page_bitmap_allocator_tb.sv
// Self-checking testbench for the next-fit page bitmap allocator.
module page_bitmap_allocator_tb import pba_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// Kind code the block treats as a no-op; the package leaves it unnamed.
	localparam logic [1:0] KIND_SPARE = 2'd3;

	// The limit covers the worst legitimate run: clearing pass, then every
	// transaction an allocate that scans the whole store after a long gap.
	localparam longint CYCLE_LIMIT = 15_000_000;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] addr;
	} alloc_reply_t;

	// Shadow of the allocator: its own bitmap, next-fit pointer and base,
	// plus the replies still owed by the block, oldest first.
	class page_ledger;
		logic [31:0]  bitmap [WORDS];
		int unsigned  scan_word;
		logic [31:0]  base;
		alloc_reply_t owed_replies [$];
		int unsigned  mismatches;

		function new();
			foreach (bitmap[i]) bitmap[i] = '0;
			scan_word  = 0;
			base       = MEMORY_BASE_RESET;
			mismatches = 0;
		endfunction

		task log_mismatch(input string msg);
			mismatches++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		// Apply one accepted transaction and queue the reply it must produce.
		function void note_request(input logic [1:0] k, input logic [31:0] a);
			alloc_reply_t r;
			logic [31:0]  offs;
			int unsigned  w;
			int unsigned  pg;
			int unsigned  b;
			bit           found;
			r.status = ST_OK;
			r.addr   = '0;
			case (k) inside
				KIND_ALLOC: begin
					// Next-fit: every word once, starting where the last hit was
					w     = (scan_word < WORDS) ? scan_word : 0;
					found = 1'b0;
					for (int n = 0; n < WORDS && !found; n++) begin
						if (bitmap[w] != '1) begin
							b = 0;
							while (bitmap[w][b]) b++;
							bitmap[w][b] = 1'b1;
							scan_word    = w;
							found        = 1'b1;
							r.addr       = base + (32'(w * 32 + b) << PAGE_SHIFT);
						end else begin
							w = (w + 1) % WORDS;
						end
					end
					if (!found) r.status = ST_NOMEM;
				end
				KIND_MARK, KIND_FREE: begin
					// Offset wraps modulo 2^32, so addresses below base are out
					offs = a - base;
					if ((offs >> PAGE_SHIFT) >= PAGE_COUNT) begin
						r.status = ST_RANGE;
					end else begin
						pg = offs >> PAGE_SHIFT;
						bitmap[pg / 32][pg % 32] = (k == KIND_MARK);
					end
				end
				default: ;
			endcase
			owed_replies.push_back(r);
		endfunction

		task check_reply(input logic [1:0] st, input logic [31:0] ad);
			alloc_reply_t r;
			if (owed_replies.size() == 0) begin
				log_mismatch($sformatf("reply st=%0d addr=%h with nothing outstanding", st, ad));
				return;
			end
			r = owed_replies.pop_front();
			if (st !== r.status)
				log_mismatch($sformatf("status %0d, predicted %0d", st, r.status));
			if (ad !== r.addr)
				log_mismatch($sformatf("result_address %h, predicted %h", ad, r.addr));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_data;
	logic        start;
	logic        busy;
	logic [1:0]  kind;
	logic [31:0] page_address;
	logic        done;
	logic [1:0]  status;
	logic [31:0] result_address;

	page_ledger  ledger;
	logic [31:0] cur_base;
	longint      cycles;
	int unsigned fill_word;

	page_bitmap_allocator DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.page_address   (page_address),
		.done           (done),
		.status         (status),
		.result_address (result_address)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Sampled on the rising edge, where the block's outputs still hold their
	// pre-edge values. Replies are checked before the new transaction is noted:
	// nothing taken at this edge can already be answered.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) ledger.check_reply(status, result_address);
			if (start && !busy) ledger.note_request(kind, page_address);
			if (cfg_we) ledger.base = cfg_data;
		end
	end

	// Idle gap after a transaction: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Address lying in page pg of the managed range (wrapping past 2^32).
	function automatic logic [31:0] page_addr(input int unsigned pg, input logic [31:0] low);
		return cur_base + (32'(pg) << PAGE_SHIFT) + low;
	endfunction

	function automatic logic [31:0] any_low();
		return 32'($urandom_range(0, (1 << PAGE_SHIFT) - 1));
	endfunction

	// Present one transaction from a falling edge and hold it until taken.
	// start is only lowered when a gap follows, so back-to-back transactions
	// never see start dropped and raised within one time step.
	task automatic send_request(input logic [1:0] k, input logic [31:0] a,
			input int unsigned gap);
		start        <= 1'b1;
		kind         <= k;
		page_address <= a;
		do @(posedge clk); while (busy);
		@(negedge clk);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic release_start();
		if (start) start <= 1'b0;
	endtask

	// Base may only change with no transaction outstanding.
	task automatic write_base(input logic [31:0] value);
		release_start();
		while (ledger.owed_replies.size() != 0 || busy) @(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we   <= 1'b0;
		cur_base  = value;
	endtask

	// Random traffic. In the normal mix half the addresses fall in the low pages
	// where allocations land, so marks and frees hit live pages. The scarce
	// mix leans towards frees and allocates spread over the whole store.
	task automatic run_random(input int unsigned count, input bit scarce);
		int unsigned nogap_left;
		int unsigned r;
		logic [1:0]  k;
		logic [31:0] a;
		nogap_left = 0;
		for (int i = 0; i < count; i++) begin
			if (nogap_left == 0 && $urandom_range(0, 9) == 0)
				nogap_left = $urandom_range(10, 30);
			r = $urandom_range(0, 99);
			if (scarce) begin
				if (r < 45) k = KIND_ALLOC;
				else if (r < 82) k = KIND_FREE;
				else if (r < 95) k = KIND_MARK;
				else k = KIND_SPARE;
			end else begin
				if (r < 40) k = KIND_ALLOC;
				else if (r < 65) k = KIND_MARK;
				else if (r < 92) k = KIND_FREE;
				else k = KIND_SPARE;
			end
			r = $urandom_range(0, 99);
			if (r < 50 && !scarce) a = page_addr($urandom_range(0, 255), any_low());
			else if (r < 80) a = page_addr($urandom_range(0, PAGE_COUNT - 1), any_low());
			else if (r < 88) a = page_addr(PAGE_COUNT, any_low());
			else if (r < 93) a = cur_base - 32'($urandom_range(1, 1 << PAGE_SHIFT));
			else a = $urandom();
			send_request(k, a, (nogap_left != 0) ? 0 : pick_gap());
			if (nogap_left != 0) nogap_left--;
		end
	endtask

	// Watchdog
	initial begin
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_data     = '0;
		start        = 1'b0;
		kind         = KIND_ALLOC;
		page_address = '0;
		cur_base     = MEMORY_BASE_RESET;
		fill_word    = 0;
		ledger       = new();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset base. The first transaction simply waits
		// out the clearing pass behind busy.
		send_request(KIND_ALLOC, '0, pick_gap());                 // lowest page of an empty store
		send_request(KIND_ALLOC, '0, pick_gap());
		send_request(KIND_MARK, page_addr(2, 32'h1fff), pick_gap()); // low bits ignored
		send_request(KIND_ALLOC, '0, pick_gap());                 // skips the marked page
		send_request(KIND_FREE, page_addr(0, 0), pick_gap());
		send_request(KIND_ALLOC, '0, pick_gap());                 // reuses page 0
		send_request(KIND_FREE, page_addr(100, 0), pick_gap());   // already clear
		send_request(KIND_MARK, page_addr(1, 32'h0800), pick_gap()); // already set
		send_request(KIND_MARK, page_addr(PAGE_COUNT - 1, 32'h1fff), pick_gap());
		send_request(KIND_FREE, page_addr(PAGE_COUNT - 1, 0), pick_gap());
		send_request(KIND_MARK, page_addr(PAGE_COUNT, 0), pick_gap()); // first page past the end
		send_request(KIND_MARK, cur_base - 1, pick_gap());        // just below base
		send_request(KIND_FREE, 32'hffff_ffff, pick_gap());
		send_request(KIND_FREE, 32'h0000_0000, pick_gap());
		send_request(KIND_SPARE, 32'hffff_ffff, pick_gap());
		send_request(KIND_SPARE, 32'h0000_0000, pick_gap());
		send_request(KIND_MARK, page_addr(33, 0), pick_gap());    // into the second word
		send_request(KIND_ALLOC, '0, pick_gap());
		send_request(KIND_ALLOC, 32'hffff_ffff, pick_gap());      // address ignored on allocate

		// Random phases across several bases, the extremes among them; pages
		// left in use carry over, only the address mapping moves.
		write_base(32'h0000_0000);
		run_random(150, 1'b0);
		write_base(32'hffff_ffff);
		run_random(150, 1'b0);
		write_base(32'($urandom_range(0, (1 << (32 - PAGE_SHIFT)) - 1)) << PAGE_SHIFT);
		run_random(150, 1'b0);
		write_base($urandom());
		run_random(150, 1'b0);

		// Fill the two words where the next search begins, back to back, so
		// allocates have to step over full words before they find a page.
		write_base(32'hffff_e000);
		fill_word = ledger.scan_word;
		for (int pg = 0; pg < 64; pg++)
			send_request(KIND_MARK,
				page_addr((fill_word * 32 + pg) % PAGE_COUNT, any_low()), 0);
		repeat (3) send_request(KIND_ALLOC, $urandom(), pick_gap());
		run_random(20, 1'b1);

		// Drain, then allow for a stray reply
		release_start();
		while (ledger.owed_replies.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (ledger.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
